FILE: design/srp_pkg.sv
// Package for the snapshot record parser: result kinds, status codes,
// parse phases, the front-to-back queue entry type and the CRC-32 byte step.
package srp_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned OutDepth = 4;
  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_KEY_BYTE  = 3'd1,
    KIND_VAL_BYTE  = 3'd2,
    KIND_EMPTY_KEY = 3'd3,
    KIND_EMPTY_VAL = 3'd4,
    KIND_STATUS    = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_CRC       = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_KEYLEN  = 3'd1,
    PH_KEYDATA = 3'd2,
    PH_VALLEN  = 3'd3,
    PH_VALDATA = 3'd4,
    PH_DONE    = 3'd5,
    PH_ERROR   = 3'd6
  } phase_e;

  typedef enum logic [0:0] {
    CFG_MAGIC   = 1'b0,
    CFG_VERSION = 1'b1
  } cfg_idx_e;

  // One released byte and/or end-of-file event passed from front to back.
  typedef struct packed {
    logic        rel_vld;
    logic [7:0]  rel_byte;
    logic        fin;
    logic        short_file;
    logic [31:0] footer;
  } front_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        field_end;
    logic [63:0] log_index;
    logic [63:0] log_term;
    logic [63:0] declared_entries;
    logic [63:0] entries_loaded;
    status_e     status;
    logic        run_end;
  } result_t;

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: design/srp_front.sv
// Front end: accepts file bytes, holds back the last four as footer,
// counts file length. Depends on srp_pkg.
module srp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 final_byte_i,
  output srp_pkg::front_item_t item_o
);

  logic [7:0] held_q [4];
  logic [7:0] held_d [4];
  logic [2:0] cnt_q, cnt_d;
  logic [5:0] pos_q, pos_d;
  logic [5:0] pos_inc;

  always_comb begin
    for (int i = 0; i < 4; i++) held_d[i] = held_q[i];
    cnt_d = cnt_q;
    pos_inc = (pos_q < 6'd36) ? pos_q + 6'd1 : pos_q;
    pos_d = pos_inc;
    item_o = '0;
    if (cnt_q[2]) begin
      item_o.rel_vld = 1'b1;
      item_o.rel_byte = held_q[0];
      held_d[0] = held_q[1];
      held_d[1] = held_q[2];
      held_d[2] = held_q[3];
      held_d[3] = data_byte_i;
    end else begin
      held_d[cnt_q[1:0]] = data_byte_i;
      cnt_d = cnt_q + 3'd1;
    end
    item_o.fin = final_byte_i;
    item_o.short_file = pos_inc < 6'd36;
    item_o.footer = {held_d[3], held_d[2], held_d[1], held_d[0]};
    if (final_byte_i) begin
      for (int i = 0; i < 4; i++) held_d[i] = '0;
      cnt_d = '0;
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= '0;
      for (int i = 0; i < 4; i++) held_q[i] <= '0;
    end else if (take_i) begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      for (int i = 0; i < 4; i++) held_q[i] <= held_d[i];
    end
  end

endmodule

FILE: design/srp_back.sv
// Back end: header parse, entry streaming, CRC and final status.
// Produces up to two results per front item. Depends on srp_pkg.
module srp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  output logic                 rdy_o,
  input  srp_pkg::front_item_t item_i,
  input  logic [31:0]          magic_i,
  input  logic [31:0]          version_i,
  input  logic                 space_i,
  output logic                 res0_vld_o,
  output srp_pkg::result_t     res0_o,
  output logic                 res1_vld_o,
  output srp_pkg::result_t     res1_o
);

  srp_pkg::phase_e ph_q, ph_d;
  logic [63:0] word_q, word_d;
  logic [31:0] rem_q, rem_d;
  logic [63:0] idx_q, idx_d, term_q, term_d, cnt_q, cnt_d, done_q, done_d;
  logic [31:0] crc_q, crc_d, crc_nb;
  logic        err_q, err_d;
  logic [4:0]  hpos;
  logic [1:0]  lpos;
  logic [31:0] len;
  logic [63:0] done_inc;
  logic        fire;
  logic        pres;
  srp_pkg::result_t pr, sr;

  assign rdy_o = space_i;
  assign fire = vld_i && space_i;
  assign crc_nb = srp_pkg::crc_step(crc_q, item_i.rel_byte);
  assign hpos = rem_q[4:0];
  assign lpos = rem_q[1:0];
  assign len = {item_i.rel_byte, word_q[23:0]};
  assign done_inc = done_q + 64'd1;

  always_comb begin
    ph_d = ph_q; word_d = word_q; rem_d = rem_q; idx_d = idx_q;
    term_d = term_q; cnt_d = cnt_q; done_d = done_q; crc_d = crc_q;
    err_d = err_q;
    pres = 1'b0;
    pr = '0;
    pr.kind = srp_pkg::KIND_HEADER;
    pr.status = srp_pkg::ST_OK;
    if (item_i.rel_vld) begin
      case (ph_q)
        srp_pkg::PH_HEADER: begin
          if (hpos >= 5'd4) crc_d = crc_nb;
          rem_d = {27'd0, hpos + 5'd1};
          case (hpos[4:3])
            2'd0: word_d[8*hpos[2:0] +: 8] = item_i.rel_byte;
            2'd1: idx_d[8*hpos[2:0] +: 8] = item_i.rel_byte;
            2'd2: term_d[8*hpos[2:0] +: 8] = item_i.rel_byte;
            default: cnt_d[8*hpos[2:0] +: 8] = item_i.rel_byte;
          endcase
          if (hpos == 5'd7 && ({item_i.rel_byte, word_q[55:32]} != version_i
              || word_q[31:0] != magic_i)) begin
            err_d = 1'b1;
            ph_d = srp_pkg::PH_ERROR;
          end
          if (hpos == 5'd31) begin
            rem_d = '0;
            word_d = '0;
            ph_d = (cnt_d == 64'd0) ? srp_pkg::PH_DONE : srp_pkg::PH_KEYLEN;
            pres = 1'b1;
            pr.kind = srp_pkg::KIND_HEADER;
            pr.log_index = idx_d;
            pr.log_term = term_d;
            pr.declared_entries = cnt_d;
          end
        end
        srp_pkg::PH_KEYLEN, srp_pkg::PH_VALLEN: begin
          crc_d = crc_nb;
          word_d[8*lpos +: 8] = item_i.rel_byte;
          rem_d = {30'd0, lpos + 2'd1};
          if (lpos == 2'd3) begin
            word_d = '0;
            rem_d = len;
            if (ph_q == srp_pkg::PH_KEYLEN) begin
              ph_d = srp_pkg::PH_KEYDATA;
              if (len == 32'd0) begin
                ph_d = srp_pkg::PH_VALLEN;
                pres = 1'b1;
                pr.kind = srp_pkg::KIND_EMPTY_KEY;
              end
            end else begin
              ph_d = srp_pkg::PH_VALDATA;
              if (len == 32'd0) begin
                done_d = done_inc;
                ph_d = (done_inc == cnt_q) ? srp_pkg::PH_DONE : srp_pkg::PH_KEYLEN;
                pres = 1'b1;
                pr.kind = srp_pkg::KIND_EMPTY_VAL;
              end
            end
          end
        end
        srp_pkg::PH_KEYDATA, srp_pkg::PH_VALDATA: begin
          crc_d = crc_nb;
          rem_d = rem_q - 32'd1;
          pres = 1'b1;
          pr.kind = (ph_q == srp_pkg::PH_KEYDATA) ? srp_pkg::KIND_KEY_BYTE
                                                  : srp_pkg::KIND_VAL_BYTE;
          pr.payload_byte = item_i.rel_byte;
          pr.field_end = (rem_d == 32'd0);
          if (rem_d == 32'd0) begin
            if (ph_q == srp_pkg::PH_KEYDATA) begin
              ph_d = srp_pkg::PH_VALLEN;
            end else begin
              done_d = done_inc;
              ph_d = (done_inc == cnt_q) ? srp_pkg::PH_DONE : srp_pkg::PH_KEYLEN;
            end
          end
        end
        srp_pkg::PH_DONE: crc_d = crc_nb;
        default: ;
      endcase
    end
    sr = '0;
    sr.kind = srp_pkg::KIND_STATUS;
    sr.entries_loaded = done_d;
    sr.run_end = 1'b1;
    if (item_i.short_file) sr.status = srp_pkg::ST_SHORT;
    else if (err_d) sr.status = srp_pkg::ST_BAD_MAGIC;
    else if (item_i.footer != ~crc_d) sr.status = srp_pkg::ST_CRC;
    else if (ph_d != srp_pkg::PH_DONE) sr.status = srp_pkg::ST_TRUNC;
    else sr.status = srp_pkg::ST_OK;
    if (sr.status == srp_pkg::ST_OK) begin
      sr.log_index = idx_d;
      sr.log_term = term_d;
      sr.declared_entries = cnt_d;
    end
    pr.run_end = !item_i.fin;
    if (item_i.fin) begin
      ph_d = srp_pkg::PH_HEADER; word_d = '0; rem_d = '0; idx_d = '0;
      term_d = '0; cnt_d = '0; done_d = '0; crc_d = '1; err_d = 1'b0;
    end
    res0_vld_o = fire && (pres || item_i.fin);
    res0_o = pres ? pr : sr;
    res1_vld_o = fire && pres && item_i.fin;
    res1_o = sr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= srp_pkg::PH_HEADER;
      word_q <= '0; rem_q <= '0; idx_q <= '0; term_q <= '0;
      cnt_q <= '0; done_q <= '0; crc_q <= '1; err_q <= 1'b0;
    end else if (fire) begin
      ph_q <= ph_d; word_q <= word_d; rem_q <= rem_d; idx_q <= idx_d;
      term_q <= term_d; cnt_q <= cnt_d; done_q <= done_d; crc_q <= crc_d;
      err_q <= err_d;
    end
  end

endmodule

FILE: design/srp_queue.sv
// Small FIFO of front items or results, with up to two writes per cycle.
// Depends on srp_pkg only through the caller's type choice.
module srp_queue #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr0_i,
  input  logic [Width-1:0] wd0_i,
  input  logic             wr1_i,
  input  logic [Width-1:0] wd1_i,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             nonempty_o,
  output logic             room2_o
);

  localparam int unsigned AW = $clog2(Depth);
  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;
  logic [AW-1:0] wp1;

  assign wp1 = wp_q + AW'(1);
  assign rdata_o = mem_q[rp_q];
  assign nonempty_o = cnt_q != '0;
  assign room2_o = cnt_q <= (AW+1)'(Depth - 2);

  always_ff @(posedge clk_i) begin
    if (wr0_i) mem_q[wp_q] <= wd0_i;
    if (wr1_i) mem_q[wp1] <= wd1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q <= wp_q + AW'(wr0_i) + AW'(wr1_i);
      rp_q <= rp_q + AW'(rd_i);
      cnt_q <= cnt_q + (AW+1)'(wr0_i) + (AW+1)'(wr1_i) - (AW+1)'(rd_i);
    end
  end

endmodule

FILE: design/snapshot_record_parser_crc32.sv
// Snapshot record parser with CRC-32 check.
// A result passes from the push that causes it through the front queue, then the
// back end into the result queue, where it can be popped; a data byte is released
// four pushes after its own. Throughput: one byte per cycle unless a queue stalls;
// a single back-end CRC/parse step per cycle sets it. Up to two results per byte.
// Reset (rst_ni low, async) empties both queues, clears parse state and registers.
module snapshot_record_parser_crc32 #(
  parameter int unsigned QDepth = srp_pkg::QueueDepth,
  parameter int unsigned ODepth = srp_pkg::OutDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        field_end_o,
  output logic [63:0] log_index_o,
  output logic [63:0] log_term_o,
  output logic [63:0] declared_entries_o,
  output logic [63:0] entries_loaded_o,
  output logic [2:0]  status_o,
  output logic        run_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned FW = $bits(srp_pkg::front_item_t);
  localparam int unsigned RW = $bits(srp_pkg::result_t);

  logic [31:0] magic_q, version_q;
  logic take, fq_ne, fq_room, rq_ne, rq_room, b_rdy, r0v, r1v;
  srp_pkg::front_item_t fitem, bitem;
  srp_pkg::result_t r0, r1, rout;
  logic [FW-1:0] fq_rd;
  logic [RW-1:0] rq_rd;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0; version_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        srp_pkg::CFG_MAGIC: magic_q <= cfg_data_i;
        srp_pkg::CFG_VERSION: version_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full = !fq_room;
  assign take = push && fq_room;

  srp_front u_front (
    .clk_i, .rst_ni, .take_i(take),
    .data_byte_i, .final_byte_i, .item_o(fitem)
  );

  srp_queue #(.Depth(QDepth), .Width(FW)) u_fq (
    .clk_i, .rst_ni, .wr0_i(take), .wd0_i(fitem), .wr1_i(1'b0), .wd1_i('0),
    .rd_i(fq_ne && b_rdy), .rdata_o(fq_rd), .nonempty_o(fq_ne), .room2_o(fq_room)
  );
  assign bitem = fq_rd;

  srp_back u_back (
    .clk_i, .rst_ni, .vld_i(fq_ne), .rdy_o(b_rdy), .item_i(bitem),
    .magic_i(magic_q), .version_i(version_q), .space_i(rq_room),
    .res0_vld_o(r0v), .res0_o(r0), .res1_vld_o(r1v), .res1_o(r1)
  );

  srp_queue #(.Depth(ODepth), .Width(RW)) u_rq (
    .clk_i, .rst_ni, .wr0_i(r0v), .wd0_i(r0), .wr1_i(r1v), .wd1_i(r1),
    .rd_i(pop && rq_ne), .rdata_o(rq_rd), .nonempty_o(rq_ne), .room2_o(rq_room)
  );
  assign rout = rq_rd;

  assign empty = !rq_ne;
  assign kind_o = rout.kind;
  assign payload_byte_o = rout.payload_byte;
  assign field_end_o = rout.field_end;
  assign log_index_o = rout.log_index;
  assign log_term_o = rout.log_term;
  assign declared_entries_o = rout.declared_entries;
  assign entries_loaded_o = rout.entries_loaded;
  assign status_o = rout.status;
  assign run_end_o = rout.run_end;

endmodule

FILE: design/srp_checker.sv
// Port-level checks for the snapshot record parser, bound to the top level.
// Depends on srp_pkg.
module srp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pop,
  input logic       empty,
  input logic [2:0] kind_o,
  input logic [2:0] status_o,
  input logic       run_end_o,
  input logic       field_end_o
);

  a_status_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != srp_pkg::ST_OK) |-> kind_o == srp_pkg::KIND_STATUS)
    else $error("status code on non-status result");
  a_status_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == srp_pkg::KIND_STATUS) |-> run_end_o)
    else $error("status result not last of run");
  a_fend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && field_end_o) |->
      (kind_o == srp_pkg::KIND_KEY_BYTE || kind_o == srp_pkg::KIND_VAL_BYTE))
    else $error("field_end on wrong kind");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(kind_o)))
    else $error("result changed while stalled");

endmodule

bind snapshot_record_parser_crc32 srp_checker u_chk (
  .clk_i, .rst_ni, .pop, .empty, .kind_o, .status_o,
  .run_end_o, .field_end_o
);
